FILE: design/tsag_pkg.sv
// shared types and constants for the tlb set address generator
// used by tsag_ctrl, tsag_datapath and the top level; no dependencies
package tsag_pkg;

	localparam int ADDR_WIDTH_DEF = 48;
	localparam int MAX_COUNT_DEF  = 64;

	localparam int SET_W      = 12;
	localparam int WANT_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int BASE_W     = 48;
	localparam int IDXB_W     = 4;
	localparam int FREE_W     = 5;
	localparam int SHIFT_W    = 6;
	localparam int OUTER_W    = 24;
	localparam int INNER_W    = 12;
	localparam int OCNT_W     = OUTER_W + 1;
	localparam int ICNT_W     = INNER_W + 1;
	localparam int PAGE_SHIFT = 12;
	localparam int SKIP_BITS  = 9;
	localparam int IDX_SAT    = 12;
	localparam int FREE_SAT   = 24;

	localparam int IN_TDATA_W = ((2 * SET_W + WANT_W + 7) / 8) * 8;

	localparam logic              XOR_MODE_RST     = 1'b1;
	localparam logic [IDXB_W-1:0] SHARED_BITS_RST  = 4'd7;
	localparam logic [IDXB_W-1:0] SPLIT_BITS_RST   = 4'd4;
	localparam logic [BASE_W-1:0] BASE_RST         = '0;
	localparam logic [FREE_W-1:0] FREE_BITS_RST    = 5'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_XOR_MODE    = 3'd0,
		CFG_SHARED_BITS = 3'd1,
		CFG_SPLIT_BITS  = 3'd2,
		CFG_BASE        = 3'd3,
		CFG_FREE_BITS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic setup;
		logic calc;
		logic merge;
		logic step;
		logic pend_load;
		logic emit_pend;
		logic fin_pend;
		logic fin_none;
		logic fin_short;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic last_cand;
		logic out_free;
	} status_t;

endpackage

FILE: design/tsag_ctrl.sv
// sequencer for the address walk: setup, per-candidate calc/merge/check, finish
// depends on tsag_pkg; drives tsag_datapath through cmd_t, reads status_t
module tsag_ctrl #(
	parameter int MAX_COUNT = tsag_pkg::MAX_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tsag_pkg::WANT_W-1:0] wanted,
	input  tsag_pkg::status_t           status,
	output tsag_pkg::cmd_t              cmd
);
	import tsag_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CALC,
		ST_MERGE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t              state_q, state_d;
	logic [WANT_W-1:0]   want_q;
	logic [WANT_W-1:0]   found_q;
	logic                pend_valid_q;
	logic [WANT_W-1:0]   want_sat;

	assign want_sat = (wanted > WANT_W'(MAX_COUNT)) ? WANT_W'(MAX_COUNT) : wanted;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && want_sat != '0) begin
					cmd.start = 1'b1;
					state_d   = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.skip) begin
					cmd.step = 1'b1;
					state_d  = status.last_cand ? ST_FINISH : ST_CALC;
				end else if (!pend_valid_q || status.out_free) begin
					// the previous find goes out once a newer one exists
					cmd.emit_pend = pend_valid_q;
					cmd.pend_load = 1'b1;
					if (found_q + WANT_W'(1) == want_q) begin
						state_d = ST_FINISH;
					end else begin
						cmd.step = 1'b1;
						state_d  = status.last_cand ? ST_FINISH : ST_CALC;
					end
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.fin_pend  = pend_valid_q;
					cmd.fin_none  = !pend_valid_q;
					cmd.fin_short = (found_q != want_q);
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			want_q       <= '0;
			found_q      <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				want_q       <= want_sat;
				found_q      <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.pend_load) begin
				found_q      <= found_q + WANT_W'(1);
				pend_valid_q <= 1'b1;
			end
			if (cmd.fin_pend || cmd.fin_none) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/tsag_datapath.sv
// config registers, walk counters, address build, skip test and output register
// depends on tsag_pkg; commanded by tsag_ctrl
module tsag_datapath #(
	parameter int ADDR_WIDTH = tsag_pkg::ADDR_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [tsag_pkg::SET_W-1:0]      shared_set,
	input  logic [tsag_pkg::SET_W-1:0]      split_set,
	input  tsag_pkg::cmd_t                  cmd,
	output tsag_pkg::status_t               status,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ADDR_WIDTH-1:0]           out_address,
	output logic                            out_last,
	output logic                            out_short
);
	import tsag_pkg::*;

	localparam logic [ADDR_WIDTH-1:0] ONES = {ADDR_WIDTH{1'b1}};
	localparam logic [ADDR_WIDTH-1:0] ONE  = ADDR_WIDTH'(1);

	// configuration
	logic              xor_q;
	logic [IDXB_W-1:0] sib_q;
	logic [IDXB_W-1:0] pib_q;
	logic [BASE_W-1:0] base_q;
	logic [FREE_W-1:0] fb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q  <= XOR_MODE_RST;
			sib_q  <= SHARED_BITS_RST;
			pib_q  <= SPLIT_BITS_RST;
			base_q <= BASE_RST;
			fb_q   <= FREE_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_XOR_MODE:    xor_q  <= cfg_wdata[0];
				CFG_SHARED_BITS: sib_q  <= cfg_wdata[IDXB_W-1:0];
				CFG_SPLIT_BITS:  pib_q  <= cfg_wdata[IDXB_W-1:0];
				CFG_BASE:        base_q <= cfg_wdata[BASE_W-1:0];
				CFG_FREE_BITS:   fb_q   <= cfg_wdata[FREE_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated field sizes and derived shift amounts
	logic [IDXB_W-1:0]     s_sat, p_sat;
	logic [FREE_W-1:0]     f_sat;
	logic [SHIFT_W-1:0]    two_s, sh, sh_p, sh_s, f_w, s_w;
	logic [OCNT_W-1:0]     n_outer_w;
	logic [ICNT_W-1:0]     n_inner_w;
	logic [ADDR_WIDTH-1:0] base_ext;

	assign s_sat    = (sib_q > IDXB_W'(IDX_SAT)) ? IDXB_W'(IDX_SAT) : sib_q;
	assign p_sat    = (pib_q > IDXB_W'(IDX_SAT)) ? IDXB_W'(IDX_SAT) : pib_q;
	assign f_sat    = (fb_q > FREE_W'(FREE_SAT)) ? FREE_W'(FREE_SAT) : fb_q;
	assign s_w      = SHIFT_W'(s_sat);
	assign f_w      = SHIFT_W'(f_sat);
	assign two_s    = s_w << 1;
	assign sh       = SHIFT_W'(PAGE_SHIFT) + two_s;
	assign sh_p     = SHIFT_W'(PAGE_SHIFT) + SHIFT_W'(p_sat);
	assign sh_s     = SHIFT_W'(PAGE_SHIFT) + s_w;
	assign base_ext = ADDR_WIDTH'(base_q);

	always_comb begin
		if (xor_q) begin
			n_outer_w = (f_w > two_s) ? (OCNT_W'(1) << (f_w - two_s)) : OCNT_W'(1);
		end else begin
			n_outer_w = (f_w > s_w) ? (OCNT_W'(1) << (f_w - s_w)) : OCNT_W'(1);
		end
		n_inner_w = (s_sat > p_sat) ? (ICNT_W'(1) << (s_sat - p_sat)) : ICNT_W'(1);
	end

	// per-request setup
	logic [SET_W-1:0]      shared_q, split_q;
	logic [IDXB_W-1:0]     s_q;
	logic                  mode_q;
	logic [ADDR_WIDTH-1:0] al_mask_q, clrp_q, rmask_q;
	logic [ADDR_WIDTH-1:0] outer_step_q, inner_step_q, lin_step_q;
	logic [OCNT_W-1:0]     n_outer_q;
	logic [ICNT_W-1:0]     n_inner_q;
	logic [ADDR_WIDTH-1:0] shared_term, split_term;

	assign shared_term = ADDR_WIDTH'(shared_q) << PAGE_SHIFT;
	assign split_term  = ADDR_WIDTH'(split_q) << PAGE_SHIFT;

	// walk state
	logic [OUTER_W-1:0]    it_q;
	logic [INNER_W-1:0]    it2_q;
	logic [ADDR_WIDTH-1:0] b_q, it_term_q, it2_term_q, right_lin_q;
	logic [ADDR_WIDTH-1:0] cand_s1, addr_s2, pend_q;
	logic [OCNT_W-1:0]     it_next;
	logic [ICNT_W-1:0]     it2_next;
	logic [ADDR_WIDTH-1:0] diff;

	assign it_next  = OCNT_W'(it_q) + OCNT_W'(1);
	assign it2_next = ICNT_W'(it2_q) + ICNT_W'(1);
	assign diff     = addr_s2 - base_ext;

	assign status.skip      = &diff[PAGE_SHIFT +: SKIP_BITS];
	assign status.last_cand = mode_q ? ((it2_next == n_inner_q) && (it_next == n_outer_q))
	                                 : (it_next == n_outer_q);
	assign status.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			shared_q     <= shared_set;
			split_q      <= split_set;
			s_q          <= s_sat;
			mode_q       <= xor_q;
			al_mask_q    <= ONES << sh;
			clrp_q       <= ONES << sh_p;
			rmask_q      <= ((ONE << s_sat) - ONE) << PAGE_SHIFT;
			outer_step_q <= ONE << sh;
			inner_step_q <= ONE << sh_p;
			lin_step_q   <= ONE << sh_s;
			n_outer_q    <= n_outer_w;
			n_inner_q    <= n_inner_w;
			it_q         <= '0;
			it2_q        <= '0;
			it_term_q    <= '0;
			it2_term_q   <= '0;
		end
		if (cmd.setup) begin
			b_q         <= base_ext & al_mask_q;
			right_lin_q <= (base_ext & al_mask_q) + shared_term;
		end
		if (cmd.calc) begin
			cand_s1 <= mode_q ? ((b_q & clrp_q) + it2_term_q + split_term)
			                  : (b_q + it_term_q);
		end
		if (cmd.merge) begin
			// xor mode folds the shared target into the bits above the shared index
			addr_s2 <= mode_q ? ((((cand_s1 & rmask_q) ^ shared_term) << s_q) | cand_s1)
			                  : (cand_s1 | right_lin_q);
		end
		if (cmd.step) begin
			if (mode_q) begin
				if (it2_next == n_inner_q) begin
					it2_q      <= '0;
					it2_term_q <= '0;
					it_q       <= it_next[OUTER_W-1:0];
					b_q        <= b_q + outer_step_q;
				end else begin
					it2_q      <= it2_next[INNER_W-1:0];
					it2_term_q <= it2_term_q + inner_step_q;
				end
			end else begin
				it_q      <= it_next[OUTER_W-1:0];
				it_term_q <= it_term_q + lin_step_q;
			end
		end
		if (cmd.pend_load) begin
			pend_q <= addr_s2;
		end
		if (cmd.emit_pend) begin
			out_address <= pend_q;
			out_last    <= 1'b0;
			out_short   <= 1'b0;
		end else if (cmd.fin_pend) begin
			out_address <= pend_q;
			out_last    <= 1'b1;
			out_short   <= cmd.fin_short;
		end else if (cmd.fin_none) begin
			out_address <= '0;
			out_last    <= 1'b1;
			out_short   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_pend || cmd.fin_pend || cmd.fin_none) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

FILE: design/tlb_set_address_generator_unit.sv
// top level of the tlb set address generator: stream ports and config port
// depends on tsag_pkg, tsag_ctrl and tsag_datapath
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  request: shared_set, split_set, wanted
// m_*       out        m_tvalid/m_tready  address, tlast = last, tuser = short_flag
// cfg_*     in         cfg_we             register index and write data
//
// one request at a time: accept, then setup, then a build, fold and skip test step
// for each walked candidate, then a finish step
// reset loads the register defaults and leaves the block idle with no transfer pending
// a second or later find waits in the skip test cycle, and the finish cycle waits,
// while the output register holds an untaken transfer; skipped candidates never wait
module tlb_set_address_generator_unit #(
	parameter int ADDR_WIDTH = tsag_pkg::ADDR_WIDTH_DEF,
	parameter int MAX_COUNT  = tsag_pkg::MAX_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// shared_set [11:0], split_set [23:12], wanted [30:24]
	input  logic [tsag_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// address [ADDR_WIDTH-1:0]
	output logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] m_tdata,
	output logic                                m_tlast,
	// short_flag [0]
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tsag_pkg::*;

	localparam int OUT_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8;

	cmd_t                  cmd;
	status_t               status;
	logic [ADDR_WIDTH-1:0] out_address;

	tsag_ctrl #(
		.MAX_COUNT(MAX_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.wanted  (s_tdata[2 * SET_W +: WANT_W]),
		.status  (status),
		.cmd     (cmd)
	);

	tsag_datapath #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.shared_set (s_tdata[0 +: SET_W]),
		.split_set  (s_tdata[SET_W +: SET_W]),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_address(out_address),
		.out_last   (m_tlast),
		.out_short  (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'(out_address);

endmodule
